FILE: rtl/c8080_pkg.sv
package c8080_pkg;

  localparam int MemAddrBits = 16;
  localparam int MemDepth = 1 << MemAddrBits;

  localparam logic [1:0] StRun = 2'd0;
  localparam logic [1:0] StHalt = 2'd1;
  localparam logic [1:0] StBad = 2'd2;

  localparam logic [4:0] FZ = 5'h01;
  localparam logic [4:0] FS = 5'h02;
  localparam logic [4:0] FP = 5'h04;
  localparam logic [4:0] FCY = 5'h08;
  localparam logic [4:0] FAC = 5'h10;

  // opcodes
  localparam logic [7:0] OpNop = 8'h00, OpLxiB = 8'h01, OpMviB = 8'h06, OpLxiD = 8'h11;
  localparam logic [7:0] OpInxD = 8'h13, OpRrc = 8'h0f, OpLdaxD = 8'h1a, OpRar = 8'h1f;
  localparam logic [7:0] OpLxiH = 8'h21, OpInxH = 8'h23, OpCma = 8'h2f, OpLxiSp = 8'h31;
  localparam logic [7:0] OpStc = 8'h37, OpCmc = 8'h3f, OpMovBC = 8'h41, OpMovBD = 8'h42;
  localparam logic [7:0] OpMovBE = 8'h43, OpHlt = 8'h76, OpMovMA = 8'h77, OpAddB = 8'h80;
  localparam logic [7:0] OpAddC = 8'h81, OpAddM = 8'h86, OpPopB = 8'hc1, OpJnz = 8'hc2;
  localparam logic [7:0] OpJmp = 8'hc3, OpPushB = 8'hc5, OpAdi = 8'hc6, OpRet = 8'hc9;
  localparam logic [7:0] OpCall = 8'hcd, OpOut = 8'hd3, OpIn = 8'hdb, OpAni = 8'he6;
  localparam logic [7:0] OpPopPsw = 8'hf1, OpDi = 8'hf3, OpPushPsw = 8'hf5, OpEi = 8'hfb;
  localparam logic [7:0] OpCpi = 8'hfe;

  typedef enum logic [3:0] {
    AsPc, AsPc1, AsPc2, AsSp, AsSp1, AsSpM1, AsSpM2, AsHl, AsDe, AsLoad
  } addr_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic       mem_en;
    logic       mem_we;
    logic [3:0] asel;
    logic [1:0] wsel;     // 0 load data, 1 hi byte, 2 lo byte, 3 A
    logic       lat_op;
    logic       lat_b1;
    logic       lat_b2;
    logic       lat_s1;   // first stack/data byte
    logic       exec;     // commit instruction
    logic       pack;     // capture output
  } cmd_t;

  typedef struct packed {
    logic [7:0] op;
    logic [1:0] stop;
  } stat_t;

  localparam logic [1:0] WLoad = 2'd0, WHi = 2'd1, WLo = 2'd2, WAcc = 2'd3;

  function automatic logic parity_even(input logic [7:0] v);
    return ~^v;
  endfunction

endpackage

FILE: rtl/c8080_if.sv
interface c8080_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] load_address;
  logic [7:0]  load_data;
  modport source(output valid, mode, load_address, load_data, input ready);
  modport sink(input valid, mode, load_address, load_data, output ready);
endinterface

interface c8080_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prog_counter;
  logic [15:0] stack_ptr;
  logic [7:0]  reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l;
  logic [4:0]  flag_bits;
  logic        irq_enabled;
  logic [1:0]  status;
  modport source(output valid, prog_counter, stack_ptr, reg_a, reg_b, reg_c, reg_d,
                 reg_e, reg_h, reg_l, flag_bits, irq_enabled, status, input ready);
  modport sink(input valid, prog_counter, stack_ptr, reg_a, reg_b, reg_c, reg_d,
               reg_e, reg_h, reg_l, flag_bits, irq_enabled, status, output ready);
endinterface

FILE: rtl/c8080_ram.sv
module c8080_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      else rdata <= mem[addr];
    end
  end
endmodule

FILE: rtl/c8080_datapath.sv
module c8080_datapath
  import c8080_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [15:0] load_address,
  input  logic [7:0]  load_data,
  c8080_out_if.source res,
  input  logic        out_take
);
  logic [15:0] pc, sp;
  logic [7:0]  ra, rb, rc, rd, re, rh, rl;
  logic [4:0]  fl;
  logic        ie;
  logic [1:0]  stop;
  logic [7:0]  op, b1, b2, s1;
  logic [15:0] addr;
  logic [7:0]  wdata, rdata;
  logic [15:0] word, hl, de, pc1, push_val;
  logic [15:0] pc_next;

  assign hl = {rh, rl};
  assign de = {rd, re};
  assign word = {b2, b1};
  assign pc1 = pc + 16'd1;
  assign stat = '{op: op, stop: stop};

  always_comb begin
    case (op)
      OpPushB:   push_val = {rb, rc};
      OpPushPsw: push_val = {ra, 3'b000, fl};
      default:   push_val = pc + 16'd3;
    endcase
  end

  // PC after the instruction commits
  always_comb begin
    case (op)
      OpLxiB, OpLxiD, OpLxiH, OpLxiSp: pc_next = pc + 16'd3;
      OpMviB, OpAdi, OpOut, OpIn, OpAni, OpCpi: pc_next = pc + 16'd2;
      OpJnz:         pc_next = fl[0] ? pc + 16'd3 : word;
      OpJmp, OpCall: pc_next = word;
      OpRet:         pc_next = {rdata, s1};
      default:       pc_next = pc1;
    endcase
  end

  always_comb begin
    case (addr_sel_t'(cmd.asel))
      AsPc:    addr = pc;
      AsPc1:   addr = pc + 16'd1;
      AsPc2:   addr = pc + 16'd2;
      AsSp:    addr = sp;
      AsSp1:   addr = sp + 16'd1;
      AsSpM1:  addr = sp - 16'd1;
      AsSpM2:  addr = sp - 16'd2;
      AsHl:    addr = hl;
      AsDe:    addr = de;
      default: addr = load_address;
    endcase
    case (cmd.wsel)
      WLoad:   wdata = load_data;
      WHi:     wdata = push_val[15:8];
      WLo:     wdata = push_val[7:0];
      default: wdata = ra;
    endcase
  end

  c8080_ram #(.Width(8), .Depth(MemDepth)) u_mem (
    .clk(clk), .en(cmd.mem_en), .we(cmd.mem_we),
    .addr(addr[MemAddrBits-1:0]), .wdata(wdata), .rdata(rdata)
  );

  // flags helper: Z S P CY, keep AC
  function automatic logic [4:0] zspc(input logic [7:0] r, input logic cy,
                                      input logic [4:0] f);
    return (f & FAC) | ((r == 8'h00) ? FZ : 5'h0) | (r[7] ? FS : 5'h0)
           | (parity_even(r) ? FP : 5'h0) | (cy ? FCY : 5'h0);
  endfunction

  logic [8:0] sum;
  logic [7:0] addend;
  always_comb begin
    case (op)
      OpAddB:  addend = rb;
      OpAddC:  addend = rc;
      OpAddM:  addend = rdata;
      default: addend = b1;
    endcase
    sum = {1'b0, ra} + {1'b0, addend};
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_op) op <= rdata;
    if (cmd.lat_b1) b1 <= rdata;
    if (cmd.lat_b2) b2 <= rdata;
    if (cmd.lat_s1) s1 <= rdata;
    if (rst) begin
      pc <= '0; sp <= '0; ra <= '0; rb <= '0; rc <= '0; rd <= '0; re <= '0;
      rh <= '0; rl <= '0; fl <= '0; ie <= 1'b0; stop <= StRun;
    end else if (cmd.exec) begin
      pc <= pc_next;
      unique case (op)
        OpNop: ;
        OpLxiB:  {rb, rc} <= word;
        OpMviB:  rb <= b1;
        OpLxiD:  {rd, re} <= word;
        OpInxD:  {rd, re} <= de + 16'd1;
        OpRrc:   begin ra <= {ra[0], ra[7:1]}; fl <= (fl & ~FCY) | (ra[0] ? FCY : 5'h0); end
        OpLdaxD: ra <= rdata;
        OpRar:   begin ra <= {fl[3], ra[7:1]}; fl <= (fl & ~FCY) | (ra[0] ? FCY : 5'h0); end
        OpLxiH:  {rh, rl} <= word;
        OpInxH:  {rh, rl} <= hl + 16'd1;
        OpCma:   ra <= ~ra;
        OpLxiSp: sp <= word;
        OpStc:   fl <= fl | FCY;
        OpCmc:   fl <= fl ^ FCY;
        OpMovBC: rb <= rc;
        OpMovBD: rb <= rd;
        OpMovBE: rb <= re;
        OpHlt:   stop <= StHalt;
        OpMovMA: ;
        OpAddB, OpAddC, OpAddM: begin ra <= sum[7:0]; fl <= zspc(sum[7:0], sum[8], fl); end
        OpAdi:   begin ra <= sum[7:0]; fl <= zspc(sum[7:0], sum[8], fl); end
        OpPopB:  begin {rb, rc} <= {rdata, s1}; sp <= sp + 16'd2; end
        OpJnz:   ;
        OpJmp:   ;
        OpPushB, OpPushPsw: sp <= sp - 16'd2;
        OpRet:   sp <= sp + 16'd2;
        OpCall:  sp <= sp - 16'd2;
        OpOut, OpIn: ;
        OpAni:   begin ra <= ra & b1; fl <= zspc(ra & b1, 1'b0, fl); end
        OpPopPsw: begin ra <= rdata; fl <= s1[4:0]; sp <= sp + 16'd2; end
        OpDi:    ie <= 1'b0;
        OpEi:    ie <= 1'b1;
        OpCpi:   fl <= zspc(ra - b1, ra < b1, fl);
        default: stop <= StBad;
      endcase
    end
  end

  // result register; valid is held until taken
  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (cmd.pack) res.valid <= 1'b1;
    else if (out_take) res.valid <= 1'b0;
    if (cmd.pack) begin
      res.prog_counter <= pc; res.stack_ptr <= sp;
      res.reg_a <= ra; res.reg_b <= rb; res.reg_c <= rc; res.reg_d <= rd;
      res.reg_e <= re; res.reg_h <= rh; res.reg_l <= rl;
      res.flag_bits <= fl; res.irq_enabled <= ie; res.status <= stop;
    end
  end
endmodule

FILE: rtl/c8080_ctrl.sv
module c8080_ctrl
  import c8080_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_mode,
  output logic  in_ready,
  input  logic  out_busy,
  input  stat_t stat,
  output cmd_t  cmd
);
  typedef enum logic [3:0] {
    Idle, FetchOp, FetchB1, FetchB2, Decode, Data1, Data2, Wr1, Wr2, Exec, Pack
  } state_t;
  state_t state;
  logic [7:0] op;
  assign op = stat.op;

  // result register must be free before a new request starts
  assign in_ready = (state == Idle) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) state <= Idle;
    else begin
      unique case (state)
        Idle: if (in_valid && in_ready) begin
          if (!in_mode || stat.stop != StRun) state <= Pack;
          else state <= FetchOp;
        end
        FetchOp: state <= FetchB1;
        FetchB1: state <= FetchB2;
        FetchB2: state <= Decode;
        Decode: begin
          case (op)
            OpPopB, OpRet, OpPopPsw, OpLdaxD, OpAddM: state <= Data1;
            OpPushB, OpPushPsw, OpCall, OpMovMA: state <= Wr1;
            default: state <= Exec;
          endcase
        end
        Data1: begin
          if (op == OpLdaxD || op == OpAddM) state <= Exec;
          else state <= Data2;
        end
        Data2: state <= Exec;
        Wr1: state <= (op == OpMovMA) ? Exec : Wr2;
        Wr2: state <= Exec;
        Exec: state <= Pack;
        Pack: state <= Idle;
        default: state <= Idle;
      endcase
    end
  end

  // memory reads launch one state before the data is latched
  logic load_wr;
  assign load_wr = (state == Idle) && in_valid && in_ready && !in_mode;

  always_comb begin
    cmd = '0;
    cmd.asel = 4'(AsLoad);
    cmd.wsel = WLoad;
    unique case (state)
      Idle: if (load_wr) begin cmd.mem_en = 1'b1; cmd.mem_we = 1'b1; end
      FetchOp: begin cmd.mem_en = 1'b1; cmd.asel = 4'(AsPc); end
      FetchB1: begin cmd.mem_en = 1'b1; cmd.asel = 4'(AsPc1); cmd.lat_op = 1'b1; end
      FetchB2: begin cmd.mem_en = 1'b1; cmd.asel = 4'(AsPc2); cmd.lat_b1 = 1'b1; end
      Decode: begin
        cmd.lat_b2 = 1'b1;
        cmd.mem_en = 1'b1;
        case (op)
          OpLdaxD: cmd.asel = 4'(AsDe);
          OpAddM:  cmd.asel = 4'(AsHl);
          OpPopB, OpRet, OpPopPsw: cmd.asel = 4'(AsSp);
          default: cmd.mem_en = 1'b0;
        endcase
      end
      Data1: begin
        cmd.lat_s1 = 1'b1;
        if (op != OpLdaxD && op != OpAddM) begin
          cmd.mem_en = 1'b1; cmd.asel = 4'(AsSp1);
        end
      end
      Data2: ;
      Wr1: begin
        cmd.mem_en = 1'b1; cmd.mem_we = 1'b1;
        if (op == OpMovMA) begin cmd.asel = 4'(AsHl); cmd.wsel = WAcc; end
        else begin cmd.asel = 4'(AsSpM1); cmd.wsel = WHi; end
      end
      Wr2: begin
        cmd.mem_en = 1'b1; cmd.mem_we = 1'b1; cmd.asel = 4'(AsSpM2); cmd.wsel = WLo;
      end
      Exec: cmd.exec = 1'b1;
      Pack: cmd.pack = 1'b1;
      default: ;
    endcase
  end
endmodule

FILE: rtl/cpu8080_subset_core.sv
// Load request: the byte is written in the accept cycle, then the result is packed.
// Execute request: three code byte reads from the single-port memory, up to two
// data or stack reads or writes, then execute and pack. A stopped core answers an
// execute request without fetching. The core takes one request at a time.
// Reset (rst, synchronous): PC, SP, registers, flags, interrupt enable and status clear.
// Memory contents are not cleared.
module cpu8080_subset_core
  import c8080_pkg::*;
(
  input logic clk,
  input logic rst,
  c8080_in_if.sink    req,
  c8080_out_if.source rsp
);
  cmd_t  cmd;
  stat_t stat;
  logic  take;

  assign take = rsp.valid && rsp.ready;

  c8080_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_mode(req.mode),
    .in_ready(req.ready), .out_busy(rsp.valid && !rsp.ready), .stat(stat), .cmd(cmd)
  );

  // datapath uses the request fields only in the accept cycle, for the load write
  c8080_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .load_address(req.load_address), .load_data(req.load_data),
    .res(rsp), .out_take(take)
  );
endmodule
